@@ hw/rtl/brainfuck_rle_core_top_defines.svh @@
// Assertion macros used by the top-level RTL file of the run-length tape language core.
`ifndef BRAINFUCK_RLE_CORE_TOP_DEFINES_SVH
`define BRAINFUCK_RLE_CORE_TOP_DEFINES_SVH

// Implication in the same cycle, disabled while reset is low.
`define BFRLE_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Implication in the next cycle, disabled while reset is low.
`define BFRLE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/bfrle_pkg.sv @@
// Package with the codes, types and decode function of the run-length tape language core.
package bfrle_pkg;

    // Input command codes.
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_EXEC  = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    // Operation codes held in the program store.
    localparam logic [2:0] OP_INC   = 3'd0;
    localparam logic [2:0] OP_DEC   = 3'd1;
    localparam logic [2:0] OP_LEFT  = 3'd2;
    localparam logic [2:0] OP_RIGHT = 3'd3;
    localparam logic [2:0] OP_OUT   = 3'd4;
    localparam logic [2:0] OP_IN    = 3'd5;
    localparam logic [2:0] OP_OPEN  = 3'd6;
    localparam logic [2:0] OP_CLOSE = 3'd7;

    // Source characters of the eight commands.
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_LT    = 8'd60;
    localparam logic [7:0] CH_GT    = 8'd62;
    localparam logic [7:0] CH_DOT   = 8'd46;
    localparam logic [7:0] CH_COMMA = 8'd44;
    localparam logic [7:0] CH_LBRK  = 8'd91;
    localparam logic [7:0] CH_RBRK  = 8'd93;

    // Fault codes.
    localparam logic [1:0] FAULT_NONE   = 2'd0;
    localparam logic [1:0] FAULT_UNMATCH = 2'd1;
    localparam logic [1:0] FAULT_FULL   = 2'd2;
    localparam logic [1:0] FAULT_DEEP   = 2'd3;

    localparam logic [7:0] RUN_MAX = 8'd255;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LD_RD,
        ST_LD_CHK,
        ST_LD_POP,
        ST_LD_J2,
        ST_LD_APP,
        ST_EX_RD,
        ST_EX_WR,
        ST_STAT_RD,
        ST_STAT_FIN
    } state_t;

    // Decoded source character.
    typedef struct packed {
        logic       known;
        logic [2:0] op;
    } decode_t;

    function automatic decode_t decode_char(input logic [7:0] c);
        decode_t d;
        d.known = 1'b1;
        d.op    = OP_INC;
        case (c)
            CH_PLUS:  d.op = OP_INC;
            CH_MINUS: d.op = OP_DEC;
            CH_LT:    d.op = OP_LEFT;
            CH_GT:    d.op = OP_RIGHT;
            CH_DOT:   d.op = OP_OUT;
            CH_COMMA: d.op = OP_IN;
            CH_LBRK:  d.op = OP_OPEN;
            CH_RBRK:  d.op = OP_CLOSE;
            default:  d.known = 1'b0;
        endcase
        return d;
    endfunction

endpackage

@@ hw/rtl/bfrle_ram.sv @@
// Simple dual-port synchronous memory with one write port and a registered read port.
module bfrle_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/brainfuck_rle_core_top.sv @@
// Top level of the run-length tape language core: sequencer, program, jump, stack and tape memories.
//
// Every item gives one result. After reset the tape is cleared one cell a cycle, so the core
// takes no item until every cell is cleared. Each item ends in the status read and finish
// states; before them an execute item passes the execute read and write states unless it does
// nothing, a no-operation, start or ignored load item passes none, an unknown character only the
// load read state, and a closing bracket takes the longest path, as its two jump entries go
// through the single write port of the jump memory. The next item can be taken in the cycle in
// which the result appears, and an item waits in the status finish state while an earlier
// result has not been taken. Paths are set by the registered memory reads: each step reads an
// entry, modifies it and writes it back before the status read of the next instruction. One
// item is handled at a time; the next item may be accepted while a result still waits to be
// taken. Loads after a fault are ignored and execute items do nothing until reset.
`include "brainfuck_rle_core_top_defines.svh"

module brainfuck_rle_core_top #(
    parameter int PROG_DEPTH = 4096,
    parameter int TAPE_CELLS = 32768,
    parameter int NEST_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command [1:0], source_char [9:2], input_byte [17:10], zero [23:18]
    input  logic [23:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_valid [0], out_byte [8:1], halted [9], needs_input [10], fault [12:11], zero [15:13]
    output logic [15:0] m_tdata
);

    localparam int AW = $clog2(PROG_DEPTH);
    localparam int LW = AW + 1;
    localparam int HW = $clog2(TAPE_CELLS);
    localparam int SW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
    localparam int TW = $clog2(NEST_DEPTH + 1);
    localparam int PW = 11;

    // Control registers.
    bfrle_pkg::state_t state_reg, state_next;
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] pc_reg, pc_next;
    logic [HW-1:0] head_reg, head_next;
    logic [HW-1:0] clr_reg, clr_next;
    logic [TW-1:0] top_reg, top_next;
    logic [1:0]    fault_reg, fault_next;
    logic          run_open_reg, run_open_next;
    logic          m_valid_reg, m_valid_next;

    // Payload registers.
    logic [1:0]    cmd_reg, cmd_next;
    logic [7:0]    char_reg, char_next;
    logic [7:0]    inb_reg, inb_next;
    logic [AW-1:0] partner_reg, partner_next;
    logic          ov_reg, ov_next;
    logic [7:0]    ob_reg, ob_next;
    logic [15:0]   m_data_reg, m_data_next;

    // Memory ports.
    logic          prog_we;
    logic [AW-1:0] prog_waddr, prog_raddr;
    logic [PW-1:0] prog_wdata, prog_rdata;
    logic          jump_we;
    logic [AW-1:0] jump_waddr;
    logic [AW-1:0] jump_wdata, jump_rdata;
    logic          stk_we;
    logic [SW-1:0] stk_waddr, stk_raddr;
    logic [AW-1:0] stk_rdata;
    logic          tape_we;
    logic [HW-1:0] tape_waddr;
    logic [7:0]    tape_wdata, tape_rdata;

    bfrle_pkg::decode_t dec;
    logic [2:0]  rd_op;
    logic [7:0]  rd_run;
    logic [HW:0] h_sum, h_dif;
    logic        halted;

    assign dec    = bfrle_pkg::decode_char(char_reg);
    assign rd_op  = prog_rdata[PW-1:8];
    assign rd_run = prog_rdata[7:0];
    assign h_sum  = {1'b0, head_reg} + {{(HW-7){1'b0}}, rd_run};
    assign h_dif  = {1'b0, head_reg} - {{(HW-7){1'b0}}, rd_run};
    assign halted = (pc_reg >= len_reg);

    assign stk_waddr  = top_reg[SW-1:0];
    assign stk_raddr  = SW'(top_reg - TW'(1));
    assign tape_waddr = (state_reg == bfrle_pkg::ST_CLEAR) ? clr_reg : head_reg;

    assign s_tready = (state_reg == bfrle_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Program store: op code and run count of each entry.
    bfrle_ram #(.DEPTH(PROG_DEPTH), .WIDTH(PW)) u_prog (
        .aclk(aclk), .we(prog_we), .waddr(prog_waddr), .wdata(prog_wdata),
        .raddr(prog_raddr), .rdata(prog_rdata)
    );

    // Jump store: partner index of each bracket.
    bfrle_ram #(.DEPTH(PROG_DEPTH), .WIDTH(AW)) u_jump (
        .aclk(aclk), .we(jump_we), .waddr(jump_waddr), .wdata(jump_wdata),
        .raddr(pc_reg[AW-1:0]), .rdata(jump_rdata)
    );

    // Stack of open bracket indices.
    bfrle_ram #(.DEPTH(NEST_DEPTH), .WIDTH(AW)) u_stack (
        .aclk(aclk), .we(stk_we), .waddr(stk_waddr), .wdata(len_reg[AW-1:0]),
        .raddr(stk_raddr), .rdata(stk_rdata)
    );

    // Tape of cells.
    bfrle_ram #(.DEPTH(TAPE_CELLS), .WIDTH(8)) u_tape (
        .aclk(aclk), .we(tape_we), .waddr(tape_waddr), .wdata(tape_wdata),
        .raddr(head_reg), .rdata(tape_rdata)
    );

    // Sequencer: next state, register updates and memory strobes.
    always_comb begin
        state_next    = state_reg;
        len_next      = len_reg;
        pc_next       = pc_reg;
        head_next     = head_reg;
        clr_next      = clr_reg;
        top_next      = top_reg;
        fault_next    = fault_reg;
        run_open_next = run_open_reg;
        m_valid_next  = m_valid_reg;
        cmd_next      = cmd_reg;
        char_next     = char_reg;
        inb_next      = inb_reg;
        partner_next  = partner_reg;
        ov_next       = ov_reg;
        ob_next       = ob_reg;
        m_data_next   = m_data_reg;
        prog_we       = 1'b0;
        prog_waddr    = len_reg[AW-1:0];
        prog_wdata    = {dec.op, 8'd1};
        prog_raddr    = pc_reg[AW-1:0];
        jump_we       = 1'b0;
        jump_waddr    = partner_reg;
        jump_wdata    = len_reg[AW-1:0];
        stk_we        = 1'b0;
        tape_we       = 1'b0;
        tape_wdata    = 8'd0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            bfrle_pkg::ST_CLEAR: begin
                tape_we  = 1'b1;
                clr_next = clr_reg + HW'(1);
                if (clr_reg == HW'(TAPE_CELLS - 1)) begin
                    state_next = bfrle_pkg::ST_IDLE;
                end
            end
            bfrle_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next  = s_tdata[1:0];
                    char_next = s_tdata[9:2];
                    inb_next  = s_tdata[17:10];
                    ov_next   = 1'b0;
                    ob_next   = 8'd0;
                    case (s_tdata[1:0])
                        bfrle_pkg::CMD_LOAD: begin
                            state_next = (fault_reg == bfrle_pkg::FAULT_NONE)
                                ? bfrle_pkg::ST_LD_RD : bfrle_pkg::ST_STAT_RD;
                        end
                        bfrle_pkg::CMD_START: begin
                            run_open_next = 1'b0;
                            if (top_reg != '0 && fault_reg == bfrle_pkg::FAULT_NONE) begin
                                fault_next = bfrle_pkg::FAULT_UNMATCH;
                            end
                            pc_next    = '0;
                            state_next = bfrle_pkg::ST_STAT_RD;
                        end
                        bfrle_pkg::CMD_EXEC: begin
                            state_next = (fault_reg == bfrle_pkg::FAULT_NONE && top_reg == '0
                                          && pc_reg < len_reg)
                                ? bfrle_pkg::ST_EX_RD : bfrle_pkg::ST_STAT_RD;
                        end
                        default: state_next = bfrle_pkg::ST_STAT_RD;
                    endcase
                end
            end
            bfrle_pkg::ST_LD_RD: begin
                // Fetch the last entry to see whether the run merges.
                prog_raddr = AW'(len_reg - LW'(1));
                if (!dec.known) begin
                    run_open_next = 1'b0;
                    state_next    = bfrle_pkg::ST_STAT_RD;
                end else begin
                    state_next = bfrle_pkg::ST_LD_CHK;
                end
            end
            bfrle_pkg::ST_LD_CHK: begin
                if (dec.op <= bfrle_pkg::OP_RIGHT && run_open_reg && len_reg != '0
                    && rd_op == dec.op && rd_run != bfrle_pkg::RUN_MAX) begin
                    prog_we    = 1'b1;
                    prog_waddr = AW'(len_reg - LW'(1));
                    prog_wdata = {rd_op, rd_run + 8'd1};
                    state_next = bfrle_pkg::ST_STAT_RD;
                end else begin
                    run_open_next = 1'b0;
                    state_next    = bfrle_pkg::ST_LD_APP;
                    if (len_reg == LW'(PROG_DEPTH)) begin
                        fault_next = bfrle_pkg::FAULT_FULL;
                        state_next = bfrle_pkg::ST_STAT_RD;
                    end else if (dec.op == bfrle_pkg::OP_OPEN) begin
                        if (top_reg == TW'(NEST_DEPTH)) begin
                            fault_next = bfrle_pkg::FAULT_DEEP;
                            state_next = bfrle_pkg::ST_STAT_RD;
                        end else begin
                            stk_we   = 1'b1;
                            top_next = top_reg + TW'(1);
                        end
                    end else if (dec.op == bfrle_pkg::OP_CLOSE) begin
                        if (top_reg == '0) begin
                            fault_next = bfrle_pkg::FAULT_UNMATCH;
                            state_next = bfrle_pkg::ST_STAT_RD;
                        end else begin
                            top_next   = top_reg - TW'(1);
                            state_next = bfrle_pkg::ST_LD_POP;
                        end
                    end
                end
            end
            bfrle_pkg::ST_LD_POP: begin
                // The open bracket now points at this closing one.
                partner_next = stk_rdata;
                jump_we      = 1'b1;
                jump_waddr   = stk_rdata;
                jump_wdata   = len_reg[AW-1:0];
                state_next   = bfrle_pkg::ST_LD_J2;
            end
            bfrle_pkg::ST_LD_J2: begin
                jump_we    = 1'b1;
                jump_waddr = len_reg[AW-1:0];
                jump_wdata = partner_reg;
                state_next = bfrle_pkg::ST_LD_APP;
            end
            bfrle_pkg::ST_LD_APP: begin
                prog_we       = 1'b1;
                len_next      = len_reg + LW'(1);
                run_open_next = (dec.op <= bfrle_pkg::OP_RIGHT);
                state_next    = bfrle_pkg::ST_STAT_RD;
            end
            bfrle_pkg::ST_EX_RD: begin
                state_next = bfrle_pkg::ST_EX_WR;
            end
            bfrle_pkg::ST_EX_WR: begin
                pc_next = pc_reg + LW'(1);
                case (rd_op)
                    bfrle_pkg::OP_INC: begin
                        tape_we    = 1'b1;
                        tape_wdata = tape_rdata + rd_run;
                    end
                    bfrle_pkg::OP_DEC: begin
                        tape_we    = 1'b1;
                        tape_wdata = tape_rdata - rd_run;
                    end
                    bfrle_pkg::OP_LEFT: begin
                        head_next = h_dif[HW] ? HW'(h_dif + (HW+1)'(TAPE_CELLS)) : h_dif[HW-1:0];
                    end
                    bfrle_pkg::OP_RIGHT: begin
                        head_next = (h_sum >= (HW+1)'(TAPE_CELLS))
                            ? HW'(h_sum - (HW+1)'(TAPE_CELLS)) : h_sum[HW-1:0];
                    end
                    bfrle_pkg::OP_OUT: begin
                        ov_next = 1'b1;
                        ob_next = tape_rdata;
                    end
                    bfrle_pkg::OP_IN: begin
                        tape_we    = 1'b1;
                        tape_wdata = inb_reg;
                    end
                    bfrle_pkg::OP_OPEN: begin
                        if (tape_rdata == 8'd0) begin
                            pc_next = {1'b0, jump_rdata} + LW'(1);
                        end
                    end
                    default: begin
                        if (tape_rdata != 8'd0) begin
                            pc_next = {1'b0, jump_rdata} + LW'(1);
                        end
                    end
                endcase
                state_next = bfrle_pkg::ST_STAT_RD;
            end
            bfrle_pkg::ST_STAT_RD: begin
                // Fetch the entry at the program counter for the status.
                state_next = bfrle_pkg::ST_STAT_FIN;
            end
            bfrle_pkg::ST_STAT_FIN: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {3'd0, fault_reg,
                                    fault_reg == bfrle_pkg::FAULT_NONE && top_reg == '0
                                    && !halted && rd_op == bfrle_pkg::OP_IN,
                                    halted, ob_reg, ov_reg};
                    state_next   = bfrle_pkg::ST_IDLE;
                end
            end
            default: state_next = bfrle_pkg::ST_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= bfrle_pkg::ST_CLEAR;
            len_reg      <= '0;
            pc_reg       <= '0;
            head_reg     <= '0;
            clr_reg      <= '0;
            top_reg      <= '0;
            fault_reg    <= bfrle_pkg::FAULT_NONE;
            run_open_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            len_reg      <= len_next;
            pc_reg       <= pc_next;
            head_reg     <= head_next;
            clr_reg      <= clr_next;
            top_reg      <= top_next;
            fault_reg    <= fault_next;
            run_open_reg <= run_open_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload.
    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        char_reg    <= char_next;
        inb_reg     <= inb_next;
        partner_reg <= partner_next;
        ov_reg      <= ov_next;
        ob_reg      <= ob_next;
        m_data_reg  <= m_data_next;
    end

    // Checks on the core's own bookkeeping.
    `BFRLE_ASSERT_NOW(a_len_bound, aclk, aresetn, 1'b1, len_reg <= LW'(PROG_DEPTH), "program length beyond store")
    `BFRLE_ASSERT_NOW(a_top_bound, aclk, aresetn, 1'b1, top_reg <= TW'(NEST_DEPTH), "bracket stack overflow")
    `BFRLE_ASSERT_NEXT(a_fault_sticky, aclk, aresetn, fault_reg != bfrle_pkg::FAULT_NONE, fault_reg == $past(fault_reg), "fault changed after being set")
    `BFRLE_ASSERT_NOW(a_no_take_clear, aclk, aresetn, state_reg == bfrle_pkg::ST_CLEAR, !s_tready, "item taken during tape clear")
    `BFRLE_ASSERT_NOW(a_exec_cmd, aclk, aresetn, state_reg == bfrle_pkg::ST_EX_WR, cmd_reg == bfrle_pkg::CMD_EXEC && pc_reg < len_reg, "execute step without execute item")

endmodule

@@ tb/testbench.sv @@
// Testbench for the run-length tape language core: directed and random stream traffic against a predictor.
`timescale 1ns / 1ps

module testbench;

    localparam int PDEPTH = 4096;
    localparam int TCELLS = 32768;
    localparam int NDEPTH = 64;
    localparam int CYCLE_LIMIT = 1500000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    brainfuck_rle_core_top i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // Predictor state.
    logic [2:0]  p_op [PDEPTH];
    logic [7:0]  p_run [PDEPTH];
    logic [11:0] p_jump [PDEPTH];
    logic [11:0] p_stack [NDEPTH];
    logic [7:0]  p_tape [TCELLS];
    int          p_top;
    int          p_len;
    int          p_pc;
    int          p_head;
    logic [1:0]  p_fault;
    logic        p_run_open;

    logic [23:0] pending_items[$];
    logic [15:0] expected_status[$];
    int          mismatches;
    int          cycles;
    bit          stim_done;
    int          gap_left;
    int          stall_left;

    // Clears the predictor to its reset state.
    function automatic void k_init();
        for (int i = 0; i < PDEPTH; i++) begin
            p_op[i] = bfrle_pkg::OP_INC;
            p_run[i] = 8'd0;
            p_jump[i] = 12'd0;
        end
        for (int i = 0; i < TCELLS; i++) p_tape[i] = 8'd0;
        p_top = 0;
        p_len = 0;
        p_pc = 0;
        p_head = 0;
        p_fault = bfrle_pkg::FAULT_NONE;
        p_run_open = 1'b0;
    endfunction

    // Appends one source character to the predicted program.
    function automatic void load_char(input logic [7:0] c);
        bfrle_pkg::decode_t d;
        d = bfrle_pkg::decode_char(c);
        if (p_fault != bfrle_pkg::FAULT_NONE) return;
        if (!d.known) begin
            p_run_open = 1'b0;
            return;
        end
        if (d.op <= bfrle_pkg::OP_RIGHT && p_run_open && p_len > 0 && p_op[p_len-1] == d.op
            && p_run[p_len-1] < bfrle_pkg::RUN_MAX) begin
            p_run[p_len-1]++;
            return;
        end
        p_run_open = 1'b0;
        if (p_len >= PDEPTH) begin
            p_fault = bfrle_pkg::FAULT_FULL;
            return;
        end
        if (d.op == bfrle_pkg::OP_OPEN) begin
            if (p_top >= NDEPTH) begin
                p_fault = bfrle_pkg::FAULT_DEEP;
                return;
            end
            p_stack[p_top] = p_len[11:0];
            p_top++;
        end else if (d.op == bfrle_pkg::OP_CLOSE) begin
            if (p_top == 0) begin
                p_fault = bfrle_pkg::FAULT_UNMATCH;
                return;
            end
            p_top--;
            p_jump[p_stack[p_top]] = p_len[11:0];
            p_jump[p_len] = p_stack[p_top];
        end
        p_op[p_len] = d.op;
        p_run[p_len] = 8'd1;
        p_len++;
        if (d.op <= bfrle_pkg::OP_RIGHT) p_run_open = 1'b1;
    endfunction

    // Works out the status word that one item produces.
    function automatic logic [15:0] predict_status(input logic [23:0] item);
        logic [1:0] cmd;
        logic       ov;
        logic [7:0] ob;
        logic       halt;
        logic       need;
        int         pc;
        int         h;
        logic [7:0] cnt;
        cmd = item[1:0];
        ov = 1'b0;
        ob = 8'd0;
        if (cmd == bfrle_pkg::CMD_LOAD) begin
            load_char(item[9:2]);
        end else if (cmd == bfrle_pkg::CMD_START) begin
            p_run_open = 1'b0;
            if (p_top != 0 && p_fault == bfrle_pkg::FAULT_NONE) p_fault = bfrle_pkg::FAULT_UNMATCH;
            p_pc = 0;
        end else if (cmd == bfrle_pkg::CMD_EXEC) begin
            if (p_fault == bfrle_pkg::FAULT_NONE && p_top == 0 && p_pc < p_len
                && p_pc < PDEPTH) begin
                pc = p_pc;
                cnt = p_run[pc];
                h = p_head;
                case (p_op[pc])
                    bfrle_pkg::OP_INC:   p_tape[h] = p_tape[h] + cnt;
                    bfrle_pkg::OP_DEC:   p_tape[h] = p_tape[h] - cnt;
                    bfrle_pkg::OP_LEFT:  h = (h + TCELLS - cnt) % TCELLS;
                    bfrle_pkg::OP_RIGHT: h = (h + cnt) % TCELLS;
                    bfrle_pkg::OP_OUT: begin
                        ov = 1'b1;
                        ob = p_tape[h];
                    end
                    bfrle_pkg::OP_IN:    p_tape[h] = item[17:10];
                    bfrle_pkg::OP_OPEN:  if (p_tape[h] == 8'd0) pc = p_jump[pc];
                    default:             if (p_tape[h] != 8'd0) pc = p_jump[pc];
                endcase
                p_head = h;
                p_pc = pc + 1;
            end
        end
        halt = p_pc >= p_len;
        need = p_fault == bfrle_pkg::FAULT_NONE && p_top == 0 && !halt && p_pc < PDEPTH
               && p_op[p_pc] == bfrle_pkg::OP_IN;
        return {3'b000, p_fault, need, halt, ob, ov};
    endfunction

    function automatic logic [23:0] make_item(input logic [1:0] cmd, input logic [7:0] ch,
                                              input logic [7:0] inb);
        return {6'd0, inb, ch, cmd};
    endfunction

    // Random character, weighted towards the six non-bracket commands.
    function automatic logic [7:0] rand_char();
        logic [7:0] cmds [8];
        cmds = '{bfrle_pkg::CH_PLUS, bfrle_pkg::CH_MINUS, bfrle_pkg::CH_LT, bfrle_pkg::CH_GT,
                 bfrle_pkg::CH_DOT, bfrle_pkg::CH_COMMA, bfrle_pkg::CH_LBRK, bfrle_pkg::CH_RBRK};
        if ($urandom_range(0, 9) == 0) return 8'($urandom);
        return cmds[$urandom_range(0, 5)];
    endfunction

    task automatic push(input logic [1:0] cmd, input logic [7:0] ch, input logic [7:0] inb);
        pending_items.push_back(make_item(cmd, ch, inb));
    endtask

    // Program: random body that is mostly bracket-free, an optional balanced loop, then start and steps.
    task automatic push_program(input int body);
        int n;
        for (n = 0; n < body; n++) push(bfrle_pkg::CMD_LOAD, rand_char(), 8'($urandom));
        if ($urandom_range(0, 1)) begin
            push(bfrle_pkg::CMD_LOAD, bfrle_pkg::CH_LBRK, 8'($urandom));
            push(bfrle_pkg::CMD_LOAD, bfrle_pkg::CH_MINUS, 8'($urandom));
            push(bfrle_pkg::CMD_LOAD, bfrle_pkg::CH_DOT, 8'($urandom));
            push(bfrle_pkg::CMD_LOAD, bfrle_pkg::CH_RBRK, 8'($urandom));
        end
        push(bfrle_pkg::CMD_START, 8'($urandom), 8'($urandom));
        for (n = 0; n < body + 8; n++)
            push($urandom_range(0, 5) == 0 ? bfrle_pkg::CMD_NOP : bfrle_pkg::CMD_EXEC,
                 8'($urandom), 8'($urandom));
    endtask

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Stimulus: directed opening, then well-formed programs with some noise.
    initial begin
        int k;
        aresetn = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        push(bfrle_pkg::CMD_NOP, 8'hFF, 8'hFF);
        push(bfrle_pkg::CMD_EXEC, 8'h00, 8'h00);
        push(bfrle_pkg::CMD_LOAD, 8'hFF, 8'h00);
        push(bfrle_pkg::CMD_LOAD, 8'h00, 8'hFF);
        push(bfrle_pkg::CMD_LOAD, bfrle_pkg::CH_PLUS, 8'h00);
        push(bfrle_pkg::CMD_LOAD, bfrle_pkg::CH_PLUS, 8'h00);
        push(bfrle_pkg::CMD_LOAD, 8'h41, 8'h00);
        push(bfrle_pkg::CMD_LOAD, bfrle_pkg::CH_PLUS, 8'h00);
        push(bfrle_pkg::CMD_LOAD, bfrle_pkg::CH_COMMA, 8'h00);
        push(bfrle_pkg::CMD_LOAD, bfrle_pkg::CH_GT, 8'h00);
        push(bfrle_pkg::CMD_LOAD, bfrle_pkg::CH_LT, 8'h00);
        push(bfrle_pkg::CMD_LOAD, bfrle_pkg::CH_LBRK, 8'h00);
        push(bfrle_pkg::CMD_EXEC, 8'h00, 8'h00);
        push(bfrle_pkg::CMD_LOAD, bfrle_pkg::CH_MINUS, 8'h00);
        push(bfrle_pkg::CMD_LOAD, bfrle_pkg::CH_DOT, 8'h00);
        push(bfrle_pkg::CMD_LOAD, bfrle_pkg::CH_RBRK, 8'h00);
        push(bfrle_pkg::CMD_START, 8'h00, 8'h00);
        for (k = 0; k < 8; k++) push(bfrle_pkg::CMD_EXEC, 8'h00, k == 2 ? 8'hFF : 8'h00);
        // Runs longer than the count byte, and a left move across cell zero.
        for (k = 0; k < 300; k++) push(bfrle_pkg::CMD_LOAD, bfrle_pkg::CH_LT, 8'h00);
        push(bfrle_pkg::CMD_START, 8'h00, 8'h00);
        for (k = 0; k < 12; k++) push(bfrle_pkg::CMD_EXEC, 8'h00, 8'h00);
        for (k = 0; k < 28; k++) push_program($urandom_range(2, 14));
        // Broken sequences and raw noise to finish, then the faults.
        for (k = 0; k < 60; k++)
            push(2'($urandom_range(0, 3)), rand_char(), 8'($urandom));
        push(bfrle_pkg::CMD_LOAD, bfrle_pkg::CH_LBRK, 8'h00);
        push(bfrle_pkg::CMD_START, 8'h00, 8'h00);
        push(bfrle_pkg::CMD_EXEC, 8'h00, 8'h00);
        push(bfrle_pkg::CMD_LOAD, bfrle_pkg::CH_PLUS, 8'h00);
        stim_done = 1'b1;
    end

    // Driver: presents pending items with random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) expected_status.push_back(predict_status(s_tdata));
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                s_tdata <= pending_items.pop_front();
                s_tvalid <= 1'b1;
                gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: compares each result with the oldest expectation, stalls at random.
    always @(posedge aclk) begin
        logic [15:0] want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_status.size() == 0) begin
                    if (mismatches < 10) $display("unexpected result %h", m_tdata);
                    mismatches++;
                end else begin
                    want = expected_status.pop_front();
                    if (want !== m_tdata) begin
                        if (mismatches < 10)
                            $display({"mismatch: valid %b/%b byte %h/%h halt %b/%b ",
                                      "need %b/%b fault %0d/%0d"},
                                     want[0], m_tdata[0], want[8:1], m_tdata[8:1], want[9],
                                     m_tdata[9], want[10], m_tdata[10], want[12:11],
                                     m_tdata[12:11]);
                        mismatches++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (m_tvalid && m_tready)
                    stall_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
            end
        end
    end

    // End of run and timeout.
    initial begin
        int tail;
        k_init();
        while (1'b1) begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("** brainfuck_rle_core_top: FAILED **");
                $finish;
            end
            if (stim_done && pending_items.size() == 0 && !s_tvalid
                && expected_status.size() == 0) break;
        end
        for (tail = 0; tail < 50; tail++) @(posedge aclk);
        if (mismatches == 0 && expected_status.size() == 0) begin
            $display("** brainfuck_rle_core_top: PASSED **");
        end else begin
            $display("** brainfuck_rle_core_top: FAILED **");
        end
        $finish;
    end

endmodule
